// ===== hdl/assert_macros.svh =====
// Assertion macros for the gamma correction port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The signal named must never be high outside reset.
`define ASSERT_NEVER(label, sig) \
  label: assert property (@(posedge clk) disable iff (rst) !(sig)) \
    else $error("signal that must stay low was seen high");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold at the delay given by n after the antecedent.
`define ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("delayed implication check failed");

`endif

// ===== hdl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamma correction package
// Shared constants, the per-channel sideband type and the power table.
// ----------------------------------------------------------------------------
package gpc_pkg;

  localparam int FRACTION_BITS_DEFAULT = 16;
  localparam logic [15:0] ONE_Q12 = 16'd4096;
  localparam logic [15:0] EXPONENT_RESET = ONE_Q12;

  typedef struct packed {
    logic       valid;
    logic       last;
    logic       zero;
    logic [7:0] alpha;
    logic [7:0] chan;
  } side_t;

  function automatic int pipe_latency(input int fb);
    return 3 * fb + 5;
  endfunction

  function automatic logic [31:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem   = v;
    res   = '0;
    bit_v = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res[31:0];
  endfunction

  // Entry k holds 2^(-2^-k) in unsigned Q0.32.
  function automatic logic [31:0] pow_entry(input int k);
    logic [31:0] t;
    t = isqrt64(64'h8000_0000_0000_0000);
    for (int j = 2; j <= k; j++) begin
      t = isqrt64({t, 32'd0});
    end
    return t;
  endfunction

endpackage

// ===== hdl/premultiplied_gamma_correction_core.sv =====
// Throughput: one pixel per cycle; busy stays low and start is taken every cycle.
// The depth is set by the division chain of the ratio, the squaring chain of
// the logarithm and the table product chain of the power, one bit per stage
// each. Results cannot be stalled.
// Reset (synchronous) clears every stage valid flag and sets the exponent to one.
// ----------------------------------------------------------------------------
// Premultiplied gamma correction core
// Colour c becomes alpha * min(1, (c/alpha)^e), or c at e = 1; alpha unchanged.
// ----------------------------------------------------------------------------
module premultiplied_gamma_correction_core #(
  parameter int FRACTION_BITS = gpc_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        exponent_we,
  input  logic [15:0] exponent_data,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  alpha_in,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic        last_pixel,
  output logic        done,
  output logic [7:0]  alpha_out,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        end_of_block
);
  import gpc_pkg::*;

  logic [15:0] exponent;
  side_t       red_side;
  side_t       green_side;
  side_t       blue_side;
  side_t       red_res;
  side_t       green_res;
  side_t       blue_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      exponent <= EXPONENT_RESET;
    end else if (exponent_we) begin
      exponent <= exponent_data;
    end
  end

  assign busy = 1'b0;

  always_comb begin
    red_side       = '{valid: start, last: last_pixel, zero: 1'b0,
                       alpha: alpha_in, chan: red_in};
    green_side     = red_side;
    green_side.chan = green_in;
    blue_side      = red_side;
    blue_side.chan = blue_in;
  end

  gpc_channel #(.FB(FRACTION_BITS)) u_red (
    .clk(clk), .rst(rst), .exponent(exponent), .in_side(red_side),
    .out_side(red_res), .value(red_out)
  );

  gpc_channel #(.FB(FRACTION_BITS)) u_green (
    .clk(clk), .rst(rst), .exponent(exponent), .in_side(green_side),
    .out_side(green_res), .value(green_out)
  );

  gpc_channel #(.FB(FRACTION_BITS)) u_blue (
    .clk(clk), .rst(rst), .exponent(exponent), .in_side(blue_side),
    .out_side(blue_res), .value(blue_out)
  );

  assign done         = red_res.valid & green_res.valid & blue_res.valid;
  assign alpha_out    = red_res.alpha;
  assign end_of_block = red_res.last;

endmodule

// ===== hdl/gpc_ratio.sv =====
// ----------------------------------------------------------------------------
// Ratio stage
// Restoring division of channel by alpha, one quotient bit per stage.
// ----------------------------------------------------------------------------
module gpc_ratio #(
  parameter int FB = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  gpc_pkg::side_t in_side,
  output gpc_pkg::side_t out_side,
  output logic [FB:0]    ratio
);
  import gpc_pkg::*;

  typedef struct packed {
    side_t         side;
    logic          sat;
    logic [7:0]    rem;
    logic [FB-1:0] quo;
  } div_t;

  div_t st [FB+1];
  div_t st0_next;

  always_comb begin
    st0_next           = '0;
    st0_next.side      = in_side;
    st0_next.side.zero = (in_side.alpha == 8'd0) || (in_side.chan == 8'd0);
    st0_next.sat       = in_side.chan >= in_side.alpha;
    st0_next.rem       = in_side.chan;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0] <= '0;
    end else begin
      st[0] <= st0_next;
    end
  end

  for (genvar i = 0; i < FB; i++) begin : g_step
    div_t       nxt;
    logic [8:0] sh;
    always_comb begin
      nxt = st[i];
      sh  = {st[i].rem, 1'b0};
      if (sh >= {1'b0, st[i].side.alpha}) begin
        nxt.rem = 8'(sh - {1'b0, st[i].side.alpha});
        nxt.quo = {st[i].quo[FB-2:0], 1'b1};
      end else begin
        nxt.rem = sh[7:0];
        nxt.quo = {st[i].quo[FB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1] <= '0;
      end else begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_side = st[FB].side;
  assign ratio = (st[FB].sat || st[FB].side.zero) ? {1'b1, {FB{1'b0}}}
                                                   : {1'b0, st[FB].quo};

endmodule

// ===== hdl/gpc_log.sv =====
// ----------------------------------------------------------------------------
// Logarithm stage
// Normalises the ratio and forms -log2 by repeated squaring, one bit a stage.
// ----------------------------------------------------------------------------
module gpc_log #(
  parameter int FB = 16,
  parameter int SW = $clog2(FB + 1),
  parameter int NW = SW + FB
) (
  input  logic           clk,
  input  logic           rst,
  input  gpc_pkg::side_t in_side,
  input  logic [FB:0]    ratio,
  output gpc_pkg::side_t out_side,
  output logic [NW-1:0]  nlog
);
  import gpc_pkg::*;

  typedef struct packed {
    side_t         side;
    logic [SW-1:0] shift;
    logic [FB:0]   m;
    logic [FB-1:0] frac;
  } lg_t;

  lg_t           st [FB+1];
  lg_t           st0_next;
  logic [SW-1:0] pos;
  logic [SW-1:0] shift;

  always_comb begin
    pos = '0;
    for (int b = 0; b <= FB; b++) begin
      if (ratio[b]) begin
        pos = SW'(b);
      end
    end
  end

  assign shift = SW'(FB) - pos;

  always_comb begin
    st0_next       = '0;
    st0_next.side  = in_side;
    st0_next.shift = shift;
    st0_next.m     = ratio << shift;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0] <= '0;
    end else begin
      st[0] <= st0_next;
    end
  end

  for (genvar i = 0; i < FB; i++) begin : g_sq
    lg_t           nxt;
    logic [2*FB+1:0] sq;
    logic [FB+1:0] t;
    always_comb begin
      nxt = st[i];
      sq  = {{(FB+1){1'b0}}, st[i].m} * {{(FB+1){1'b0}}, st[i].m};
      t   = sq[2*FB+1:FB];
      if (t[FB+1]) begin
        nxt.m    = t[FB+1:1];
        nxt.frac = {st[i].frac[FB-2:0], 1'b1};
      end else begin
        nxt.m    = t[FB:0];
        nxt.frac = {st[i].frac[FB-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1] <= '0;
      end else begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_side = st[FB].side;
  assign nlog = {st[FB].shift, {FB{1'b0}}} - {{SW{1'b0}}, st[FB].frac};

endmodule

// ===== hdl/gpc_exp.sv =====
// ----------------------------------------------------------------------------
// Power stage
// Scales the logarithm by the exponent and forms 2^-P from a table product.
// ----------------------------------------------------------------------------
module gpc_exp #(
  parameter int FB = 16,
  parameter int SW = $clog2(FB + 1),
  parameter int NW = SW + FB
) (
  input  logic           clk,
  input  logic           rst,
  input  gpc_pkg::side_t in_side,
  input  logic [NW-1:0]  nlog,
  input  logic [15:0]    exponent,
  output gpc_pkg::side_t out_side,
  output logic [FB:0]    power
);
  import gpc_pkg::*;

  localparam int PW = NW + 4;
  localparam int QW = PW - FB;

  typedef struct packed {
    side_t         side;
    logic [QW-1:0] q;
    logic [FB-1:0] f;
    logic          one;
    logic [31:0]   r;
  } ex_t;

  ex_t            st [FB+1];
  ex_t            st0_next;
  logic [NW+15:0] prod;
  side_t          side_q;
  logic [FB:0]    power_q;
  logic [32:0]    rr;
  logic [32:0]    shifted;

  assign prod = {16'd0, nlog} * {{NW{1'b0}}, exponent};

  always_comb begin
    st0_next      = '0;
    st0_next.side = in_side;
    st0_next.q    = prod[NW+15:FB+12];
    st0_next.f    = prod[FB+11:12];
    st0_next.one  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0] <= '0;
    end else begin
      st[0] <= st0_next;
    end
  end

  for (genvar i = 0; i < FB; i++) begin : g_tab
    localparam logic [31:0] TK = pow_entry(i + 1);
    ex_t         nxt;
    logic [63:0] mul;
    always_comb begin
      nxt = st[i];
      mul = {32'd0, st[i].r} * {32'd0, TK};
      if (st[i].f[FB-1-i]) begin
        nxt.one = 1'b0;
        nxt.r   = st[i].one ? TK : mul[63:32];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1] <= '0;
      end else begin
        st[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    rr      = st[FB].one ? {1'b1, 32'd0} : {1'b0, st[FB].r};
    shifted = (st[FB].q > QW'(32)) ? 33'd0 : (rr >> st[FB].q);
  end

  always_ff @(posedge clk) begin
    power_q <= shifted[32:32-FB];
    if (rst) begin
      side_q <= '0;
    end else begin
      side_q <= st[FB].side;
    end
  end

  assign out_side = side_q;
  assign power    = power_q;

endmodule

// ===== hdl/gpc_channel.sv =====
// ----------------------------------------------------------------------------
// Channel pipeline
// Ratio, logarithm and power stages followed by scaling back by alpha.
// ----------------------------------------------------------------------------
module gpc_channel #(
  parameter int FB = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    exponent,
  input  gpc_pkg::side_t in_side,
  output gpc_pkg::side_t out_side,
  output logic [7:0]     value
);
  import gpc_pkg::*;

  localparam int SW = $clog2(FB + 1);
  localparam int NW = SW + FB;

  side_t         ratio_side;
  side_t         log_side;
  side_t         exp_side;
  side_t         side_q;
  logic [FB:0]   ratio;
  logic [NW-1:0] nlog;
  logic [FB:0]   power;
  logic [FB+8:0] prod;
  logic [7:0]    value_next;
  logic [7:0]    value_q;

  gpc_ratio #(.FB(FB)) u_ratio (
    .clk(clk), .rst(rst), .in_side(in_side), .out_side(ratio_side), .ratio(ratio)
  );

  gpc_log #(.FB(FB), .SW(SW), .NW(NW)) u_log (
    .clk(clk), .rst(rst), .in_side(ratio_side), .ratio(ratio),
    .out_side(log_side), .nlog(nlog)
  );

  gpc_exp #(.FB(FB), .SW(SW), .NW(NW)) u_exp (
    .clk(clk), .rst(rst), .in_side(log_side), .nlog(nlog), .exponent(exponent),
    .out_side(exp_side), .power(power)
  );

  assign prod = {{(FB+1){1'b0}}, exp_side.alpha} * {8'd0, power};

  always_comb begin
    if (exponent == ONE_Q12) begin
      value_next = exp_side.chan;
    end else if (exp_side.zero) begin
      value_next = 8'd0;
    end else begin
      value_next = prod[FB+7:FB];
    end
  end

  always_ff @(posedge clk) begin
    value_q <= value_next;
    if (rst) begin
      side_q <= '0;
    end else begin
      side_q <= exp_side;
    end
  end

  assign out_side = side_q;
  assign value    = value_q;

endmodule

// ===== hdl/gpc_checker.sv =====
// ----------------------------------------------------------------------------
// Gamma correction port checker
// Watches the top level ports for latency and pass-through behaviour.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpc_checker #(
  parameter int FRACTION_BITS = gpc_pkg::FRACTION_BITS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  input logic        exponent_we,
  input logic [15:0] exponent_data,
  input logic        start,
  input logic        busy,
  input logic [7:0]  alpha_in,
  input logic [7:0]  red_in,
  input logic [7:0]  green_in,
  input logic [7:0]  blue_in,
  input logic        last_pixel,
  input logic        done,
  input logic [7:0]  alpha_out,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic        end_of_block
);
  import gpc_pkg::*;

  localparam int LAT = pipe_latency(FRACTION_BITS);

  `ASSERT_NEVER(a_never_busy, busy)
  `ASSERT_IMPL(a_done_has_transfer, done, $past(start, LAT))
  `ASSERT_DELAY(a_transfer_gives_done, start, LAT, done)
  `ASSERT_DELAY(a_alpha_passes, start, LAT, alpha_out == $past(alpha_in, LAT))

endmodule

bind premultiplied_gamma_correction_core gpc_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_gpc_checker (.*);

// ===== bench/tb_premultiplied_gamma_correction_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Premultiplied gamma correction core testbench
// Drives pixels through the start/busy handshake under random gaps, predicts
// each corrected pixel in fixed point and compares every done transfer.
// ----------------------------------------------------------------------------
module tb_premultiplied_gamma_correction_core;

  localparam int FB = gpc_pkg::FRACTION_BITS_DEFAULT;
  localparam int LATENCY = 3 * FB + 5;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic        clk;
  logic        rst;
  logic        exponent_we;
  logic [15:0] exponent_data;
  logic        start;
  logic        busy;
  logic [7:0]  alpha_in;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic        last_pixel;
  logic        done;
  logic [7:0]  alpha_out;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        end_of_block;

  logic [15:0] gamma_exp;
  logic [63:0] root_table [0:24];
  pixel_t      corrected_q [$];
  int          fail_count;
  int          cycle_count;
  bit          no_gaps;

  premultiplied_gamma_correction_core dut (
    .clk(clk), .rst(rst),
    .exponent_we(exponent_we), .exponent_data(exponent_data),
    .start(start), .busy(busy),
    .alpha_in(alpha_in), .red_in(red_in), .green_in(green_in),
    .blue_in(blue_in), .last_pixel(last_pixel),
    .done(done), .alpha_out(alpha_out), .red_out(red_out),
    .green_out(green_out), .blue_out(blue_out), .end_of_block(end_of_block)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] trial;
    acc = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic logic [63:0] minus_log2(input logic [63:0] x);
    int          top;
    logic [63:0] m;
    logic [63:0] frac;
    top = 0;
    frac = '0;
    for (int i = 0; i <= FB; i++) if (x[i]) top = i;
    m = x << (FB - top);
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> FB;
      frac = frac << 1;
      if (m >= (64'd2 << FB)) begin
        frac = frac | 64'd1;
        m = m >> 1;
      end
    end
    return (64'(FB - top) << FB) - frac;
  endfunction

  function automatic logic [63:0] pow2_neg(input logic [63:0] pv);
    logic [63:0] whole;
    logic [63:0] r;
    whole = pv >> FB;
    r = 64'd1 << 32;
    for (int k = 1; k <= FB; k++)
      if (pv[FB - k]) r = (r * root_table[k]) >> 32;
    if (whole > 32) return '0;
    r = r >> whole;
    return r >> (32 - FB);
  endfunction

  function automatic logic [7:0] gamma_channel(input logic [7:0] c, input logic [7:0] a);
    logic [63:0] ratio;
    logic [63:0] pw;
    if (a == 0 || c == 0) return '0;
    if (c >= a) ratio = 64'd1 << FB;
    else ratio = (64'(c) << FB) / a;
    pw = pow2_neg((minus_log2(ratio) * gamma_exp) >> 12);
    return 8'((64'(a) * pw) >> FB);
  endfunction

  function automatic pixel_t correct_pixel(input pixel_t p);
    pixel_t o;
    o = p;
    if (gamma_exp != gpc_pkg::ONE_Q12) begin
      o.red   = gamma_channel(p.red, p.alpha);
      o.green = gamma_channel(p.green, p.alpha);
      o.blue  = gamma_channel(p.blue, p.alpha);
    end
    return o;
  endfunction

  task automatic send_pixel(input pixel_t p);
    if (!no_gaps) begin
      while ($urandom_range(99) < 11) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    alpha_in   <= p.alpha;
    red_in     <= p.red;
    green_in   <= p.green;
    blue_in    <= p.blue;
    last_pixel <= p.last;
    do @(posedge clk); while (busy);
    corrected_q.push_back(correct_pixel(p));
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic set_exponent(input logic [15:0] value);
    drain_pipe();
    exponent_we   <= 1'b1;
    exponent_data <= value;
    @(posedge clk);
    exponent_we <= 1'b0;
    gamma_exp = value;
  endtask

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.alpha = 8'($urandom_range(255));
    case ($urandom_range(3))
      0: p.alpha = 8'd255;
      1: p.alpha = 8'($urandom_range(15));
      default: ;
    endcase
    p.red   = 8'($urandom_range(255));
    p.green = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(p.alpha));
    p.blue  = 8'($urandom_range(p.alpha));
    p.last  = ($urandom_range(7) == 0);
    return p;
  endfunction

  task automatic test_directed(input logic [15:0] value);
    set_exponent(value);
    send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
    send_pixel('{8'd0, 8'd255, 8'd128, 8'd1, 1'b1});
    send_pixel('{8'd255, 8'd255, 8'd0, 8'd1, 1'b0});
    send_pixel('{8'd255, 8'd128, 8'd64, 8'd254, 1'b0});
    send_pixel('{8'd1, 8'd1, 8'd0, 8'd255, 1'b1});
    send_pixel('{8'd100, 8'd200, 8'd99, 8'd50, 1'b0});
    send_pixel('{8'd128, 8'd127, 8'd3, 8'd170, 1'b1});
  endtask

  task automatic test_random(input logic [15:0] value, input int count);
    set_exponent(value);
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= count / 3) && (i < count / 2);
      send_pixel(random_pixel());
    end
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (corrected_q.size() == 0) begin
        $error("result transfer with no pixel outstanding");
        fail_count++;
      end else begin
        pixel_t want;
        want = corrected_q.pop_front();
        if (alpha_out !== want.alpha) begin
          $error("alpha_out expected %0d actual %0d", want.alpha, alpha_out);
          fail_count++;
        end
        if (red_out !== want.red) begin
          $error("red_out expected %0d actual %0d", want.red, red_out);
          fail_count++;
        end
        if (green_out !== want.green) begin
          $error("green_out expected %0d actual %0d", want.green, green_out);
          fail_count++;
        end
        if (blue_out !== want.blue) begin
          $error("blue_out expected %0d actual %0d", want.blue, blue_out);
          fail_count++;
        end
        if (end_of_block !== want.last) begin
          $error("end_of_block expected %0d actual %0d", want.last, end_of_block);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    fail_count    = 0;
    cycle_count   = 0;
    no_gaps       = 1'b0;
    gamma_exp     = gpc_pkg::EXPONENT_RESET;
    rst           = 1'b1;
    exponent_we   = 1'b0;
    exponent_data = '0;
    start         = 1'b0;
    alpha_in      = '0;
    red_in        = '0;
    green_in      = '0;
    blue_in       = '0;
    last_pixel    = 1'b0;
    root_table[0] = 64'd1 << 32;
    root_table[1] = int_root(64'd1 << 63);
    for (int k = 2; k <= 24; k++) root_table[k] = int_root(root_table[k - 1] << 32);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed(gpc_pkg::ONE_Q12);
    test_directed(16'd1861);
    test_directed(16'd0);
    test_directed(16'd65535);
    test_random(16'd1861, 250);
    test_random(16'd1, 120);
    test_random(16'd65535, 120);
    test_random(gpc_pkg::ONE_Q12, 100);
    test_random(16'd9011, 200);
    test_random(16'd2048, 150);
    test_random(16'(($urandom_range(65535))), 150);

    drain_pipe();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
